/* rtl/core/gbi_pkg.sv */
// Shared types and constants of the grid bilinear interpolator.
// No dependencies; every module of the block imports it.
`default_nettype none

package gbi_pkg;

  // Opcode of an input beat
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Latitude offset: 90 degrees in units of 1/256 degree
  localparam int LAT_OFFSET = 23040;

  // Result queue depth and the width of counters that reach it
  localparam int OUT_DEPTH = 8;
  localparam int PTR_W     = $clog2(OUT_DEPTH);
  localparam int CRED_W    = PTR_W + 1;

  typedef enum logic [1:0] {
    KIND_POINT    = 2'd0,
    KIND_ROW_MEAN = 2'd1,
    KIND_COL_MEAN = 2'd2,
    KIND_BILINEAR = 2'd3
  } kind_t;

  typedef struct packed {
    logic               opcode;
    logic [9:0]         load_row;
    logic [10:0]        load_col;
    logic signed [31:0] load_depth;
    logic signed [15:0] query_lat;
    logic [16:0]        query_lon;
  } item_t;

  typedef struct packed {
    logic signed [31:0] depth_out;
    kind_t              result_kind;
  } result_t;

  // Decoded item handed from the index pipeline to the fetch sequencer
  typedef struct packed {
    logic  valid;
    logic  query;
    logic  wr_en;
    kind_t kind;
  } item_ctl_t;

  // Tag that travels with each memory read beat
  typedef struct packed {
    logic  valid;
    logic  row_last;
    logic  item_last;
    kind_t kind;
  } beat_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/gbi_index.sv */
// Index pipeline: turns an input beat into row bases, column, fractions and kind.
// Three stages sharing one advance enable; depends on gbi_pkg.
`default_nettype none

module gbi_index #(
  parameter int GRID_ROWS      = 721,
  parameter int GRID_COLS      = 1440,
  parameter int STEP_FRAC_BITS = 6,
  localparam int RW = $clog2(GRID_ROWS),
  localparam int CW = $clog2(GRID_COLS),
  localparam int AW = $clog2(GRID_ROWS * GRID_COLS),
  localparam int F  = STEP_FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  gbi_pkg::item_t      item,
  input  logic                take,
  output gbi_pkg::item_ctl_t  ctl,
  output logic [AW-1:0]       rb0,
  output logic [AW-1:0]       rb1,
  output logic [CW-1:0]       c0,
  output logic [F-1:0]        fx,
  output logic [F-1:0]        fy,
  output logic signed [31:0]  data
);
  import gbi_pkg::*;

  localparam int XW   = 17 - F;
  localparam int K    = XW + CW;
  localparam int MW   = XW + 2;
  localparam int MULW = RW + CW + 1;
  localparam int QW   = XW + MW;
  localparam int RCW  = XW + CW + 1;
  localparam int UMAX = (GRID_ROWS - 1) * (1 << F);
  localparam longint M_L = ((longint'(1) << K) + longint'(GRID_COLS) - 1) /
                           longint'(GRID_COLS);
  localparam logic [MW-1:0]  M_V     = MW'(M_L);
  localparam logic [CW:0]    COLS_V  = (CW + 1)'(GRID_COLS);
  localparam logic [RW-1:0]  ROW_TOP = RW'(GRID_ROWS - 1);
  localparam logic [31:0]    ROWS_U  = 32'(GRID_ROWS);
  localparam logic [31:0]    COLS_U  = 32'(GRID_COLS);

  logic adv;

  // Stage 1 combinational decode
  logic signed [17:0] u_s;
  logic [15:0]        uc;
  logic [RW-1:0]      r0_d, r1_d;
  logic [F-1:0]       fy_d, fx_d;
  kind_t              kind_d;
  logic               wr_ok_d;

  // Stage registers
  item_ctl_t          s1_ctl, s2_ctl;
  logic [RW-1:0]      s1_r0, s1_r1;
  logic [XW-1:0]      s1_x, s2_x, s2_q;
  logic [F-1:0]       s1_fx, s1_fy, s2_fx, s2_fy;
  logic [CW-1:0]      s1_lcol, s2_lcol;
  logic signed [31:0] s1_data, s2_data;
  logic [AW-1:0]      s2_rb0, s2_rb1;

  logic [QW-1:0]      q_prod;
  logic [RCW-1:0]     qc;
  logic [XW-1:0]      rem;

  // Advance all stages when the last one is empty or handed off
  assign adv        = !ctl.valid || take;
  assign item_stall = !adv;

  // Offset and clamp the latitude, split positions into index and fraction
  always_comb begin
    u_s = 18'(item.query_lat) + 18'(LAT_OFFSET);
    if (u_s < 18'sd0) begin
      uc = '0;
    end else if (32'(u_s) > UMAX) begin
      uc = 16'(UMAX);
    end else begin
      uc = 16'(u_s);
    end
    fy_d = uc[F-1:0];
    fx_d = item.query_lon[F-1:0];
    if (item.opcode == OP_QUERY) begin
      r0_d = RW'(32'(uc) >> F);
    end else begin
      r0_d = RW'(item.load_row);
    end
    r1_d = (r0_d == ROW_TOP || item.opcode == OP_LOAD) ? r0_d : r0_d + RW'(1);
    if (fy_d == '0 && fx_d == '0) begin
      kind_d = KIND_POINT;
    end else if (fy_d == '0) begin
      kind_d = KIND_ROW_MEAN;
    end else if (fx_d == '0) begin
      kind_d = KIND_COL_MEAN;
    end else begin
      kind_d = KIND_BILINEAR;
    end
    wr_ok_d = (32'(item.load_row) < ROWS_U) && (32'(item.load_col) < COLS_U);
  end

  // Column quotient and remainder by reciprocal multiplication
  assign q_prod = QW'(s1_x) * QW'(M_V);
  assign qc     = RCW'(s2_q) * RCW'(COLS_V);
  assign rem    = s2_x - qc[XW-1:0];

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
      s2_ctl <= '0;
      ctl    <= '0;
    end else if (adv) begin
      s1_ctl.valid <= item_valid;
      s1_ctl.query <= (item.opcode == OP_QUERY);
      s1_ctl.wr_en <= wr_ok_d;
      s1_ctl.kind  <= kind_d;
      s2_ctl       <= s1_ctl;
      ctl          <= s2_ctl;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r0   <= r0_d;
      s1_r1   <= r1_d;
      s1_x    <= item.query_lon[16:F];
      s1_fx   <= fx_d;
      s1_fy   <= fy_d;
      s1_lcol <= CW'(item.load_col);
      s1_data <= item.load_depth;

      s2_rb0  <= AW'(MULW'(s1_r0) * MULW'(COLS_V));
      s2_rb1  <= AW'(MULW'(s1_r1) * MULW'(COLS_V));
      s2_q    <= XW'(q_prod >> K);
      s2_x    <= s1_x;
      s2_fx   <= s1_fx;
      s2_fy   <= s1_fy;
      s2_lcol <= s1_lcol;
      s2_data <= s1_data;

      rb0  <= s2_rb0;
      rb1  <= s2_rb1;
      c0   <= s2_ctl.query ? CW'(rem) : s2_lcol;
      fx   <= s2_fx;
      fy   <= s2_fy;
      data <= s2_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/gbi_fetch.sv */
// Fetch sequencer and grid memory: one write per in-range load, one to four reads per query.
// A started query issues a read beat with its weights and tag each cycle; depends on gbi_pkg.
`default_nettype none

module gbi_fetch #(
  parameter int GRID_ROWS      = 721,
  parameter int GRID_COLS      = 1440,
  parameter int STEP_FRAC_BITS = 6,
  localparam int CW = $clog2(GRID_COLS),
  localparam int AW = $clog2(GRID_ROWS * GRID_COLS),
  localparam int F  = STEP_FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  gbi_pkg::item_ctl_t  ctl,
  input  logic [AW-1:0]       rb0,
  input  logic [AW-1:0]       rb1,
  input  logic [CW-1:0]       c0,
  input  logic [F-1:0]        fx,
  input  logic [F-1:0]        fy,
  input  logic signed [31:0]  data,
  input  logic                pop,
  output logic                take,
  output gbi_pkg::beat_ctl_t  bctl,
  output logic [F:0]          wx,
  output logic [F:0]          wy,
  output logic signed [31:0]  rdata
);
  import gbi_pkg::*;

  localparam int DEPTH = GRID_ROWS * GRID_COLS;
  localparam logic [F:0]    S_V     = {1'b1, {F{1'b0}}};
  localparam logic [F:0]    HALF_V  = S_V >> 1;
  localparam logic [CW-1:0] COL_TOP = CW'(GRID_COLS - 1);

  logic signed [31:0] grid [0:DEPTH-1];

  logic [1:0]        step, last_step;
  logic [CRED_W-1:0] credits;
  logic              col_sel, row_sel, start_ok, go, start;
  logic [CW-1:0]     c1, col;
  logic [AW-1:0]     addr;
  logic [F:0]        wx_d, wy_d;

  // Pick the neighbor and weights for this step
  always_comb begin
    unique case (ctl.kind)
      KIND_POINT:    last_step = 2'd0;
      KIND_ROW_MEAN: last_step = 2'd1;
      KIND_COL_MEAN: last_step = 2'd1;
      KIND_BILINEAR: last_step = 2'd3;
      default:       last_step = 2'd0;
    endcase
    col_sel = ctl.query && step[0] &&
              (ctl.kind == KIND_ROW_MEAN || ctl.kind == KIND_BILINEAR);
    row_sel = ctl.query &&
              ((ctl.kind == KIND_COL_MEAN && step[0]) ||
               (ctl.kind == KIND_BILINEAR && step[1]));
    c1   = (c0 == COL_TOP) ? '0 : c0 + CW'(1);
    col  = col_sel ? c1 : c0;
    addr = (row_sel ? rb1 : rb0) + AW'(col);
    unique case (ctl.kind)
      KIND_POINT: begin
        wx_d = S_V;
        wy_d = S_V;
      end
      KIND_ROW_MEAN: begin
        wx_d = HALF_V;
        wy_d = S_V;
      end
      KIND_COL_MEAN: begin
        wx_d = S_V;
        wy_d = HALF_V;
      end
      default: begin
        wx_d = col_sel ? {1'b0, fx} : S_V - {1'b0, fx};
        wy_d = row_sel ? {1'b0, fy} : S_V - {1'b0, fy};
      end
    endcase
  end

  // Start a query only with room reserved in the result queue
  assign start_ok = !ctl.query || step != 2'd0 || credits < CRED_W'(OUT_DEPTH);
  assign go       = ctl.valid && start_ok;
  assign start    = go && ctl.query && step == 2'd0;
  assign take     = go && (!ctl.query || step == last_step);

  // Advance the step counter and the reservation count
  always_ff @(posedge clk) begin
    if (rst) begin
      step    <= 2'd0;
      credits <= '0;
      bctl    <= '0;
    end else begin
      if (go) begin
        step <= take ? 2'd0 : step + 2'd1;
      end
      credits <= credits + CRED_W'(start) - CRED_W'(pop);
      bctl.valid     <= go && ctl.query;
      bctl.row_last  <= step[0] || ctl.kind == KIND_POINT || ctl.kind == KIND_COL_MEAN;
      bctl.item_last <= step == last_step;
      bctl.kind      <= ctl.kind;
    end
  end

  // Single-port grid memory: write an in-range load, read a query neighbor
  always_ff @(posedge clk) begin
    if (go) begin
      if (!ctl.query) begin
        if (ctl.wr_en) begin
          grid[addr] <= data;
        end
      end else begin
        rdata <= grid[addr];
      end
    end
    wx <= wx_d;
    wy <= wy_d;
  end

  // Item stays presented through its whole sequence
  a_item_held: assert property (@(posedge clk) disable iff (rst)
    step != 2'd0 |-> ctl.valid)
    else $error("fetch sequence lost its item");

  // Reservations never exceed the result queue
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credits <= CRED_W'(OUT_DEPTH))
    else $error("result reservations exceed queue depth");

endmodule

`default_nettype wire

/* rtl/core/gbi_blend.sv */
// Blend datapath and result queue: weights each read, sums rows, sums the item.
// Fed by gbi_fetch read beats; depends on gbi_pkg.
`default_nettype none

module gbi_blend #(
  parameter int STEP_FRAC_BITS = 6,
  localparam int F = STEP_FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  gbi_pkg::beat_ctl_t  bctl,
  input  logic [F:0]          wx,
  input  logic [F:0]          wy,
  input  logic signed [31:0]  rdata,
  input  logic                result_stall,
  output logic                result_valid,
  output gbi_pkg::result_t    result
);
  import gbi_pkg::*;

  localparam int PW = 33 + F;
  localparam int TW = 33 + 2 * F;

  // Weighted sample stage
  logic               p_valid;
  beat_ctl_t          p_ctl;
  logic [F:0]         p_wy;
  logic signed [PW-1:0] prod;

  // Row sum stage
  logic               row_open, rv, r_last;
  kind_t              r_kind;
  logic [F:0]         r_wy;
  logic signed [PW-1:0] rowacc, row_sum;

  // Row weight stage and item total
  logic               p2_valid, p2_last, tot_open, push;
  kind_t              p2_kind;
  logic signed [TW-1:0] p2, tot, tsum, shifted;

  // Result queue
  result_t            fifo [0:OUT_DEPTH-1];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CRED_W-1:0]  count;
  logic               pop;

  assign row_sum = row_open ? rowacc + prod : prod;
  assign tsum    = tot_open ? tot + p2 : p2;
  assign shifted = tsum >>> (2 * F);
  assign push    = p2_valid && p2_last;
  assign pop     = result_valid && !result_stall;

  // Hold control state of the pipeline and the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid  <= 1'b0;
      row_open <= 1'b0;
      rv       <= 1'b0;
      p2_valid <= 1'b0;
      tot_open <= 1'b0;
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      count    <= '0;
    end else begin
      p_valid  <= bctl.valid;
      rv       <= p_valid && p_ctl.row_last;
      p2_valid <= rv;
      if (p_valid) begin
        row_open <= !p_ctl.row_last;
      end
      if (p2_valid) begin
        tot_open <= !p2_last;
      end
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CRED_W'(push) - CRED_W'(pop);
    end
  end

  // Advance the arithmetic payload
  always_ff @(posedge clk) begin
    prod  <= PW'(rdata) * PW'($signed({1'b0, wx}));
    p_ctl <= bctl;
    p_wy  <= wy;
    if (p_valid) begin
      rowacc <= row_sum;
      r_wy   <= p_wy;
      r_last <= p_ctl.item_last;
      r_kind <= p_ctl.kind;
    end
    p2      <= TW'(rowacc) * TW'($signed({1'b0, r_wy}));
    p2_last <= r_last;
    p2_kind <= r_kind;
    if (p2_valid) begin
      tot <= tsum;
    end
    if (push) begin
      fifo[wr_ptr].depth_out   <= shifted[31:0];
      fifo[wr_ptr].result_kind <= p2_kind;
    end
  end

  assign result_valid = count != '0;
  assign result       = fifo[rd_ptr];

  // The last read beat of a query passes the weighted sample, row sum and row weight stages into the queue
  a_beat_to_push: assert property (@(posedge clk) disable iff (rst)
    bctl.valid && bctl.item_last |-> ##3 push)
    else $error("query result did not reach the queue");

  // The queue is never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && count == CRED_W'(OUT_DEPTH)))
    else $error("result queue overflow");

endmodule

`default_nettype wire

/* rtl/core/grid_bilinear_interpolator.sv */
// Grid bilinear interpolator top: index pipeline, fetch sequencer with grid memory, blend.
// Each load takes one turn on the memory port; queries take one, two, two or four grid reads
// (exact, row mean, column mean, bilinear), at one grid read per cycle on the single
// memory port while the query has room reserved in the result queue.
// Reset clears all control state; grid contents are undefined until loaded.
`default_nettype none

module grid_bilinear_interpolator #(
  parameter int GRID_ROWS      = 721,
  parameter int GRID_COLS      = 1440,
  parameter int STEP_FRAC_BITS = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  gbi_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_stall,
  output gbi_pkg::result_t  result
);
  import gbi_pkg::*;

  localparam int CW = $clog2(GRID_COLS);
  localparam int AW = $clog2(GRID_ROWS * GRID_COLS);
  localparam int F  = STEP_FRAC_BITS;

  item_ctl_t          ctl;
  beat_ctl_t          bctl;
  logic [AW-1:0]      rb0, rb1;
  logic [CW-1:0]      c0;
  logic [F-1:0]       fx, fy;
  logic [F:0]         wx, wy;
  logic signed [31:0] data, rdata;
  logic               take, pop;

  // Result beat leaves the queue
  assign pop = result_valid && !result_stall;

  gbi_index #(
    .GRID_ROWS      (GRID_ROWS),
    .GRID_COLS      (GRID_COLS),
    .STEP_FRAC_BITS (STEP_FRAC_BITS)
  ) u_index (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .take       (take),
    .ctl        (ctl),
    .rb0        (rb0),
    .rb1        (rb1),
    .c0         (c0),
    .fx         (fx),
    .fy         (fy),
    .data       (data)
  );

  gbi_fetch #(
    .GRID_ROWS      (GRID_ROWS),
    .GRID_COLS      (GRID_COLS),
    .STEP_FRAC_BITS (STEP_FRAC_BITS)
  ) u_fetch (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .rb0   (rb0),
    .rb1   (rb1),
    .c0    (c0),
    .fx    (fx),
    .fy    (fy),
    .data  (data),
    .pop   (pop),
    .take  (take),
    .bctl  (bctl),
    .wx    (wx),
    .wy    (wy),
    .rdata (rdata)
  );

  gbi_blend #(
    .STEP_FRAC_BITS (STEP_FRAC_BITS)
  ) u_blend (
    .clk          (clk),
    .rst          (rst),
    .bctl         (bctl),
    .wx           (wx),
    .wy           (wy),
    .rdata        (rdata),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

`default_nettype wire
